>>> sv/gbef_pkg.sv
`timescale 1ns / 1ps

package gbef_pkg;

  // default map size
  localparam int DEF_MAX_COLS = 64;
  localparam int DEF_MAX_ROWS = 64;

  // field widths
  localparam int COORD_W    = 6;
  localparam int GRID_W     = 7;
  localparam int TSIZE_W    = 9;
  localparam int PIX_W      = 14;
  localparam int VAL_W      = 16;
  localparam int DIR_W      = 2;
  localparam int CNT_W      = 11;
  localparam int WADDR_W    = 21;
  localparam int S_TDATA_W  = 32;
  localparam int M_TDATA_W  = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [PIX_W-1:0]        PIX_MAX    = '1;
  localparam logic signed [VAL_W-1:0] TILE_EMPTY = -16'sd1;

  // request kinds
  localparam logic REQ_STORE   = 1'b0;
  localparam logic REQ_EXAMINE = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_W    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_H    = 2'd3;

  // map probe steps
  localparam logic [2:0] STEP_CENTRE = 3'd0;
  localparam logic [2:0] STEP_UP     = 3'd1;
  localparam logic [2:0] STEP_RIGHT  = 3'd2;
  localparam logic [2:0] STEP_DOWN   = 3'd3;
  localparam logic [2:0] STEP_LEFT   = 3'd4;

  // edge directions
  localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
  localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd1;
  localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd2;
  localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd3;

  // cell position status from the probe unit
  typedef struct packed {
    logic       in_grid;
    logic       in_map;
    logic [3:0] border;
  } probe_t;

endpackage

>>> sv/gbef_ram.sv
`timescale 1ns / 1ps

module gbef_ram #(
  parameter int WIDTH  = 1,
  parameter int DEPTH  = 2,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic [ADDR_W-1:0] addr,
  input  logic              we,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> sv/gbef_probe.sv
`timescale 1ns / 1ps

module gbef_probe #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64,
  parameter int ADDR_W   = 12
) (
  input  logic [gbef_pkg::COORD_W-1:0] col,
  input  logic [gbef_pkg::COORD_W-1:0] row,
  input  logic [2:0]                   sel,
  input  logic [gbef_pkg::GRID_W-1:0]  grid_cols,
  input  logic [gbef_pkg::GRID_W-1:0]  grid_rows,
  output logic [ADDR_W-1:0]            addr,
  output gbef_pkg::probe_t             status
);

  import gbef_pkg::*;

  logic [GRID_W-1:0]  col_x;
  logic [GRID_W-1:0]  row_x;
  logic [GRID_W-1:0]  col_inc;
  logic [GRID_W-1:0]  row_inc;
  logic [GRID_W-1:0]  ncol;
  logic [GRID_W-1:0]  nrow;
  logic [WADDR_W-1:0] addr_wide;

  assign col_x   = {1'b0, col};
  assign row_x   = {1'b0, row};
  assign col_inc = col_x + GRID_W'(1);
  assign row_inc = row_x + GRID_W'(1);

  // below both the grid in use and the map size
  function automatic logic lt_cols(input logic [GRID_W-1:0] a, input logic [GRID_W-1:0] lim);
    lt_cols = (a < lim) && (CNT_W'(a) < CNT_W'(MAX_COLS));
  endfunction

  function automatic logic lt_rows(input logic [GRID_W-1:0] a, input logic [GRID_W-1:0] lim);
    lt_rows = (a < lim) && (CNT_W'(a) < CNT_W'(MAX_ROWS));
  endfunction

  always_comb begin
    status.in_grid           = lt_cols(col_x, grid_cols) && lt_rows(row_x, grid_rows);
    status.in_map            = (CNT_W'(col_x) < CNT_W'(MAX_COLS)) &&
                               (CNT_W'(row_x) < CNT_W'(MAX_ROWS));
    status.border[DIR_UP]    = (row == '0);
    status.border[DIR_RIGHT] = !lt_cols(col_inc, grid_cols);
    status.border[DIR_DOWN]  = !lt_rows(row_inc, grid_rows);
    status.border[DIR_LEFT]  = (col == '0);
  end

  // neighbour coordinates; a wrapped value only happens on a border side
  always_comb begin
    unique case (sel)
      STEP_UP: begin
        ncol = col_x;
        nrow = row_x - GRID_W'(1);
      end
      STEP_RIGHT: begin
        ncol = col_inc;
        nrow = row_x;
      end
      STEP_DOWN: begin
        ncol = col_x;
        nrow = row_inc;
      end
      STEP_LEFT: begin
        ncol = col_x - GRID_W'(1);
        nrow = row_x;
      end
      default: begin
        ncol = col_x;
        nrow = row_x;
      end
    endcase
  end

  assign addr_wide = WADDR_W'(nrow) * WADDR_W'(MAX_COLS) + WADDR_W'(ncol);
  assign addr      = addr_wide[ADDR_W-1:0];

endmodule

>>> sv/gbef_pixmul.sv
`timescale 1ns / 1ps

module gbef_pixmul (
  input  logic [gbef_pkg::COORD_W-1:0] coord,
  input  logic [gbef_pkg::TSIZE_W-1:0] tsize,
  output logic [gbef_pkg::PIX_W-1:0]   pix
);

  import gbef_pkg::*;

  localparam int PROD_W = COORD_W + TSIZE_W;

  logic [PROD_W-1:0] prod;

  assign prod = PROD_W'(coord) * PROD_W'(tsize);

  // saturate to the pixel range
  assign pix = (prod > PROD_W'(PIX_MAX)) ? PIX_MAX : prod[PIX_W-1:0];

endmodule

>>> sv/grid_boundary_edge_finder.sv
`timescale 1ns / 1ps

// channel | direction | handshake          | content
// s_      | in        | s_tvalid/s_tready  | request word: kind in tuser, cell and tile in tdata
// m_      | out       | m_tvalid/m_tready  | result word: edge flag in tuser, last in tlast
// cfg_    | in        | cfg_valid/cfg_ready| register index and write data
//
// after reset the map is swept to empty, one cell a cycle, over all MAX_COLS*MAX_ROWS cells
// (4096 by default); s_tready stays low meanwhile, cfg writes are taken as ever
// a store writes its cell, then loads a final no-edge result before the next accept
// an examine reads the cell and its four neighbours one bit a cycle through the single map
// port, then results leave one a cycle while m_tready allows
// the result register lets a finished word wait on m_tready while a new word is accepted;
// a stall on m_tready holds the sequencer in its output step

module grid_boundary_edge_finder #(
  parameter int MAX_COLS = gbef_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = gbef_pkg::DEF_MAX_ROWS
) (
  input  logic                            clk,
  input  logic                            rst,
  // tdata: cell_col[5:0], cell_row[11:6], tile_value[27:12], zero pad
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [gbef_pkg::S_TDATA_W-1:0]  s_tdata,
  // tuser: req_type[0]
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // tdata: edge_dir[1:0], pixel_x[15:2], pixel_y[29:16], zero pad
  output logic [gbef_pkg::M_TDATA_W-1:0]  m_tdata,
  // tuser: edge_valid[0]
  output logic                            m_tuser,
  output logic                            m_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [gbef_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gbef_pkg::CFG_DATA_W-1:0] cfg_data
);

  import gbef_pkg::*;

  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // sequencer states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_STORE = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_CAPT  = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;
  localparam logic [2:0] S_NONE  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  // configuration
  logic [GRID_W-1:0]  grid_cols;
  logic [GRID_W-1:0]  grid_rows;
  logic [TSIZE_W-1:0] tile_w;
  logic [TSIZE_W-1:0] tile_h;

  // held request
  logic               req_r;
  logic [COORD_W-1:0] col_r;
  logic [COORD_W-1:0] row_r;
  logic               val_empty;

  // probe sequencing
  logic [2:0]    st;
  logic [2:0]    cap_st;
  logic          cap_pend;
  logic          centre_empty;
  logic [3:0]    open_bits;
  logic [AW-1:0] clr_addr;

  logic [PIX_W-1:0] px;
  logic [PIX_W-1:0] py;

  // map port
  logic [AW-1:0] probe_addr;
  probe_t        status;
  logic [AW-1:0] ram_addr;
  logic          ram_we;
  logic          ram_wdata;
  logic          ram_rdata;

  // shared multiplier
  logic [COORD_W-1:0] mul_coord;
  logic [TSIZE_W-1:0] mul_tsize;
  logic [PIX_W-1:0]   mul_pix;

  // result selection
  logic [DIR_W-1:0] pick;
  logic [3:0]       rest;
  logic [2:0]       cap_off;
  logic [DIR_W-1:0] cap_dir;
  logic             out_free;
  logic             out_load;
  logic             out_edge;
  logic             out_last;
  logic             no_edge;
  logic             in_acc;

  assign in_acc    = s_tvalid && s_tready;
  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;

  gbef_probe #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS),
    .ADDR_W   (AW)
  ) u_probe (
    .col       (col_r),
    .row       (row_r),
    .sel       (st),
    .grid_cols (grid_cols),
    .grid_rows (grid_rows),
    .addr      (probe_addr),
    .status    (status)
  );

  gbef_ram #(
    .WIDTH  (1),
    .DEPTH  (DEPTH),
    .ADDR_W (AW)
  ) u_map (
    .clk   (clk),
    .addr  (ram_addr),
    .we    (ram_we),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // column product on the centre step, row product on the next
  assign mul_coord = (st == STEP_CENTRE) ? col_r : row_r;
  assign mul_tsize = (st == STEP_CENTRE) ? tile_w : tile_h;

  gbef_pixmul u_pixmul (
    .coord (mul_coord),
    .tsize (mul_tsize),
    .pix   (mul_pix)
  );

  // map port: sweep, store or neighbour read (1 = empty)
  always_comb begin
    ram_addr  = probe_addr;
    ram_we    = 1'b0;
    ram_wdata = val_empty;
    if (state == S_CLEAR) begin
      ram_addr  = clr_addr;
      ram_we    = 1'b1;
      ram_wdata = 1'b1;
    end else if (state == S_STORE) begin
      ram_we = status.in_map;
    end
  end

  // lowest open side goes first
  always_comb begin
    pick = DIR_UP;
    for (int i = 3; i >= 0; i--) begin
      if (open_bits[i]) begin
        pick = DIR_W'(i);
      end
    end
    rest = open_bits & ~(4'b0001 << pick);
  end

  assign cap_off = cap_st - STEP_UP;
  assign cap_dir = cap_off[DIR_W-1:0];
  assign no_edge = !status.in_grid || centre_empty || (open_bits == 4'b0000);

  always_comb begin
    state_next = state;
    out_load   = 1'b0;
    out_edge   = 1'b0;
    out_last   = 1'b1;
    unique case (state)
      S_CLEAR: begin
        if (clr_addr == AW'(DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          state_next = (s_tuser == REQ_STORE) ? S_STORE : S_READ;
        end
      end
      S_STORE: begin
        state_next = S_NONE;
      end
      S_READ: begin
        if (st == STEP_LEFT) begin
          state_next = S_CAPT;
        end
      end
      S_CAPT: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (!no_edge) begin
            out_edge = 1'b1;
            out_last = (rest == 4'b0000);
          end
          if (out_last) begin
            state_next = S_IDLE;
          end
        end
      end
      S_NONE: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      cap_pend <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      cap_pend <= (state == S_READ);
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_cols <= GRID_W'(DEF_MAX_COLS);
      grid_rows <= GRID_W'(DEF_MAX_ROWS);
      tile_w    <= TSIZE_W'(32);
      tile_h    <= TSIZE_W'(32);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GRID_COLS: grid_cols <= cfg_data[GRID_W-1:0];
        REG_GRID_ROWS: grid_rows <= cfg_data[GRID_W-1:0];
        REG_TILE_W:    tile_w    <= cfg_data;
        REG_TILE_H:    tile_h    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r     <= s_tuser;
      col_r     <= s_tdata[5:0];
      row_r     <= s_tdata[11:6];
      val_empty <= ($signed(s_tdata[27:12]) == TILE_EMPTY);
      st        <= STEP_CENTRE;
    end
    if (state == S_READ) begin
      cap_st <= st;
      if (st != STEP_LEFT) begin
        st <= st + 3'd1;
      end
      if (st == STEP_CENTRE) begin
        px <= mul_pix;
      end
      if (st == STEP_UP) begin
        py <= mul_pix;
      end
    end
    // read data arrives in the cycle after its address
    if (cap_pend) begin
      if (cap_st == STEP_CENTRE) begin
        centre_empty <= ram_rdata;
      end else begin
        open_bits[cap_dir] <= status.border[cap_dir] | ram_rdata;
      end
    end
    if (state == S_EMIT && out_load && !no_edge) begin
      open_bits <= rest;
    end
    if (out_load) begin
      m_tuser <= out_edge;
      m_tlast <= out_last;
      if (out_edge) begin
        m_tdata <= {2'b00, py, px, pick};
      end else begin
        m_tdata <= '0;
      end
    end
  end

  // no result leaves during the sweep
  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !m_tvalid)
    else $error("result during map sweep");

  // a result without an edge always closes its request
  a_none_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> m_tlast)
    else $error("no-edge result not final");

  // no request taken while a map read is still in flight
  a_acc_no_read: assert property (@(posedge clk) disable iff (rst)
    in_acc |-> !cap_pend)
    else $error("request taken during map read");

  // a final edge result returns the sequencer to idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && out_load && out_last) |=> (state == S_IDLE))
    else $error("sequencer not idle after final result");

  // stores never reach the probe steps
  a_store_path: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> (req_r == REQ_EXAMINE))
    else $error("store request in map read");

endmodule
